/* hdl/fdme_pkg.sv */
// Package for the finite difference motion estimator.
// Holds the fixed widths and the result word type; no dependencies.
package fdme_pkg;

  localparam int AddrW  = 48;
  localparam int FormW  = 32;
  localparam int PosW   = 32;
  localparam int GapW   = 24;
  localparam int SpeedW = 31;
  localparam int UsecPerSec = 1000000;

  // Timestamp width, and the fraction bits of the Q23.8 position format.
  localparam int TimeW       = 48;
  localparam int PosFracBits = 8;

  // Difference times one million, as a magnitude: 33 bits times 20 bits.
  localparam int NumW = 53;

  typedef struct packed {
    logic                   identity_ok;
    logic                   identity_new;
    logic                   position_ok;
    logic                   velocity_ok;
    logic signed [PosW-1:0] velocity_x;
    logic signed [PosW-1:0] velocity_y;
    logic signed [PosW-1:0] velocity_z;
    logic [SpeedW-1:0]      speed_out;
    logic                   accel_ok;
    logic signed [PosW-1:0] accel_out;
    logic [GapW-1:0]        gap_us;
  } fdme_result_t;

  // Handshake between the top level and one divider lane.
  typedef struct packed {
    logic start;
    logic busy;
  } fdme_div_ctl_t;

endpackage

/* hdl/fdme_if.sv */
// Valid/ready channel interfaces for the input, result and configuration words.
// Depends on fdme_pkg.
interface fdme_in_if;
  import fdme_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   identity_readable;
  logic [AddrW-1:0]       object_address;
  logic [FormW-1:0]       object_form_id;
  logic                   position_readable;
  logic [TimeW-1:0]       sample_time_us;
  logic signed [PosW-1:0] position_x;
  logic signed [PosW-1:0] position_y;
  logic signed [PosW-1:0] position_z;
  modport source (output valid, identity_readable, object_address, object_form_id,
                  position_readable, sample_time_us, position_x, position_y, position_z,
                  input ready);
  modport sink (input valid, identity_readable, object_address, object_form_id,
                position_readable, sample_time_us, position_x, position_y, position_z,
                output ready);
endinterface

interface fdme_out_if;
  import fdme_pkg::*;
  logic         valid;
  logic         ready;
  fdme_result_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface fdme_cfg_if;
  import fdme_pkg::*;
  logic            valid;
  logic            ready;
  logic [GapW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* hdl/finite_difference_motion_estimator_top.sv */
// Top level of the finite difference motion estimator.
// Depends on fdme_pkg, the channel interfaces, fdme_div_lane and fdme_isqrt.
//
// One sample at a time; the next word is taken only once the result word has
// left. A sample that is not differenced gives its result in the cycle after it
// is taken. A differenced sample goes through these steps: latch the differences,
// three divider lanes working on x, y and z side by side, the squares summed,
// the square root and a final step to finish. When a stored speed allows an
// acceleration, all three lanes divide the speed change again and the x lane's
// quotient is used. Stalls on the result side delay the taking of the next word.
// The result sits in an output register.
module finite_difference_motion_estimator_top import fdme_pkg::*; (
  input logic clk,
  input logic rst,
  fdme_in_if.sink   in_ch,
  fdme_out_if.source out_ch,
  fdme_cfg_if.sink  cfg
);
  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_VDIV, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_ROOT, S_ADIV, S_OUT
  } state_t;

  state_t state;
  logic [GapW-1:0]    max_interval_us;
  logic               identity_valid;
  logic [AddrW-1:0]   held_address;
  logic [FormW-1:0]   held_form_id;
  logic               last_pos_valid;
  logic [TimeW-1:0]   last_time_us;
  logic signed [PosW-1:0] last_pos [3];
  logic               last_speed_valid;
  logic signed [PosW-1:0] last_speed;

  fdme_result_t       res;
  fdme_result_t       res_head;
  logic               out_valid;
  logic [GapW-1:0]    gap;
  logic signed [PosW:0] diff [3];
  logic               lane_start;
  logic               lane_neg [3];
  logic [NumW-1:0]    lane_mag [3];
  fdme_div_ctl_t      lane_ctl [3];
  logic signed [NumW:0] lane_q [3];
  logic               ok;
  logic [63:0]        sq_acc;
  logic [31:0]        mag_r;
  logic [63:0]        prod;
  logic               rt_start;
  logic               rt_busy;
  logic [31:0]        root;
  logic               accel_start;
  logic signed [PosW:0] speed_diff;

  // Input fields and the identity checks.
  logic [TimeW-1:0] now;
  logic        id_bad;
  logic        changed;
  assign now = in_ch.sample_time_us;
  assign id_bad = !in_ch.identity_readable || in_ch.object_address == '0 ||
                  in_ch.object_form_id == '0;
  assign changed = !identity_valid || in_ch.object_address != held_address ||
                   in_ch.object_form_id != held_form_id;

  assign in_ch.ready  = (state == S_IDLE) && !out_valid;
  assign cfg.ready    = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = res;

  // Flags of the result word that are known as soon as a sample is taken.
  always_comb begin
    res_head = '0;
    res_head.identity_ok  = !id_bad;
    res_head.identity_new = !id_bad && changed;
    res_head.position_ok  = !id_bad && in_ch.position_readable;
  end

  function automatic logic fits32(input logic signed [NumW:0] v);
    return v >= -(NumW+1)'(64'sd2147483648) && v <= (NumW+1)'(64'sd2147483647);
  endfunction

  // Lane operands: velocity uses the differences, acceleration the speed change.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [PosW:0] d;
      d = (state == S_ROOT || state == S_ADIV) ? speed_diff : diff[i];
      lane_neg[i] = d[PosW];
      lane_mag[i] = NumW'(d[PosW] ? -d : d) * NumW'(UsecPerSec);
    end
  end

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_lane
      fdme_div_lane u_lane (
        .clk, .rst, .start(lane_start), .neg(lane_neg[g]), .mag(lane_mag[g]),
        .divisor(gap), .ctl(lane_ctl[g]), .quot(lane_q[g])
      );
    end
  endgenerate

  fdme_isqrt u_root (
    .clk, .rst, .start(rt_start), .radicand(sq_acc), .busy(rt_busy), .root(root)
  );

  assign lane_start = (state == S_DIFF) || accel_start;
  assign speed_diff = $signed({2'b00, root[30:0]}) - $signed({last_speed[PosW-1], last_speed});
  assign prod = 64'(mag_r) * 64'(mag_r);

  // Sequencer, state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      max_interval_us  <= GapW'(UsecPerSec);
      identity_valid   <= 1'b0;
      last_pos_valid   <= 1'b0;
      last_speed_valid <= 1'b0;
      held_address     <= '0;
      held_form_id     <= '0;
      last_time_us     <= '0;
      last_pos[0]      <= '0;
      last_pos[1]      <= '0;
      last_pos[2]      <= '0;
      last_speed       <= '0;
      rt_start         <= 1'b0;
      accel_start      <= 1'b0;
    end else begin
      rt_start    <= 1'b0;
      accel_start <= 1'b0;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (cfg.valid && cfg.ready) max_interval_us <= cfg.data;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            res <= res_head;
            if (id_bad) begin
              identity_valid   <= 1'b0;
              held_address     <= '0;
              held_form_id     <= '0;
              last_pos_valid   <= 1'b0;
              last_speed_valid <= 1'b0;
              last_speed       <= '0;
              last_time_us     <= '0;
              out_valid        <= 1'b1;
            end else begin
              identity_valid   <= 1'b1;
              held_address     <= in_ch.object_address;
              held_form_id     <= in_ch.object_form_id;
              if (!in_ch.position_readable) begin
                last_pos_valid   <= 1'b0;
                last_speed_valid <= 1'b0;
                last_speed       <= '0;
                last_time_us     <= '0;
                out_valid        <= 1'b1;
              end else begin
                last_pos_valid <= 1'b1;
                last_time_us   <= now;
                last_pos[0] <= in_ch.position_x;
                last_pos[1] <= in_ch.position_y;
                last_pos[2] <= in_ch.position_z;
                if (changed) begin
                  last_speed_valid <= 1'b0;
                  last_speed       <= '0;
                end
                if (!changed && last_pos_valid && now > last_time_us) begin
                  if ((now - last_time_us) <= TimeW'(max_interval_us)) begin
                    gap <= GapW'(now - last_time_us);
                    diff[0] <= $signed({in_ch.position_x[PosW-1], in_ch.position_x}) -
                               $signed({last_pos[0][PosW-1], last_pos[0]});
                    diff[1] <= $signed({in_ch.position_y[PosW-1], in_ch.position_y}) -
                               $signed({last_pos[1][PosW-1], last_pos[1]});
                    diff[2] <= $signed({in_ch.position_z[PosW-1], in_ch.position_z}) -
                               $signed({last_pos[2][PosW-1], last_pos[2]});
                    state <= S_DIFF;
                  end else begin
                    last_speed_valid <= 1'b0;
                    last_speed       <= '0;
                    out_valid        <= 1'b1;
                  end
                end else begin
                  out_valid <= 1'b1;
                end
              end
            end
          end
        end
        S_DIFF: state <= S_VDIV;
        S_VDIV: begin
          if (!lane_ctl[0].busy) begin
            ok     <= fits32(lane_q[0]) && fits32(lane_q[1]) && fits32(lane_q[2]);
            sq_acc <= '0;
            mag_r  <= 32'(lane_q[0][NumW] ? -lane_q[0] : lane_q[0]);
            state  <= S_SQ0;
          end
        end
        S_SQ0: begin
          sq_acc <= sq_acc + prod;
          mag_r  <= 32'(lane_q[1][NumW] ? -lane_q[1] : lane_q[1]);
          state  <= S_SQ1;
        end
        S_SQ1: begin
          sq_acc <= sq_acc + prod;
          mag_r  <= 32'(lane_q[2][NumW] ? -lane_q[2] : lane_q[2]);
          state  <= S_SQ2;
        end
        S_SQ2: begin
          sq_acc   <= sq_acc + prod;
          state    <= S_SQ3;
        end
        S_SQ3: begin
          rt_start <= 1'b1;
          state    <= S_ROOT;
        end
        S_ROOT: begin
          if (!rt_start && !rt_busy) begin
            if (!ok || root[31]) begin
              last_speed_valid <= 1'b0;
              last_speed       <= '0;
              state            <= S_OUT;
            end else begin
              res.velocity_ok <= 1'b1;
              res.velocity_x  <= PosW'(lane_q[0]);
              res.velocity_y  <= PosW'(lane_q[1]);
              res.velocity_z  <= PosW'(lane_q[2]);
              res.speed_out   <= root[SpeedW-1:0];
              res.gap_us      <= gap;
              if (last_speed_valid) begin
                accel_start <= 1'b1;
                state       <= S_ADIV;
              end else begin
                last_speed_valid <= 1'b1;
                last_speed       <= $signed({1'b0, root[SpeedW-1:0]});
                state            <= S_OUT;
              end
            end
          end
        end
        S_ADIV: begin
          if (!accel_start && !lane_ctl[0].busy) begin
            if (fits32(lane_q[0])) begin
              res.accel_ok  <= 1'b1;
              res.accel_out <= PosW'(lane_q[0]);
            end
            last_speed <= $signed({1'b0, root[SpeedW-1:0]});
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* hdl/fdme_div_lane.sv */
// One restoring divider lane: signed numerator over an unsigned 24-bit gap.
// Gives the quotient truncated toward zero, one bit a cycle. Depends on fdme_pkg.
module fdme_div_lane import fdme_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   neg,
  input  logic [NumW-1:0]        mag,
  input  logic [GapW-1:0]        divisor,
  output fdme_div_ctl_t          ctl,
  output logic signed [NumW:0]   quot
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q;
  logic [GapW:0]   rem;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic            sign;
  logic [GapW:0]   trial;

  assign trial = {rem[GapW-1:0], q[NumW-1]};

  // Shift one numerator bit into the remainder each cycle while busy.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntW'(NumW);
      q    <= mag;
      rem  <= '0;
      sign <= neg;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= trial - {1'b0, divisor};
        q   <= {q[NumW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[NumW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) busy <= 1'b0;
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign quot = sign ? -$signed({1'b0, q}) : $signed({1'b0, q});
endmodule

/* hdl/fdme_isqrt.sv */
// Serial integer square root of a 64-bit value, two bits a cycle.
// Depends on fdme_pkg.
module fdme_isqrt import fdme_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic [31:0] root
);
  logic [63:0] n;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = res + bitv;

  // Classic digit-by-digit method; bit walks down from 2^62.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      n    <= radicand;
      res  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (n >= trial) begin
        n   <= n - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      if (bitv[0]) busy <= 1'b0;
    end
  end

  assign root = res[31:0];
endmodule

/* hdl/fdme_checker.sv */
// Port-level checker for the motion estimator, bound to the top level.
// Depends on fdme_pkg and the channel interfaces.
module fdme_checker import fdme_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input fdme_result_t out_data
);
  // A result word holds while it waits.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result word changed while stalled");

  // No new input word while a result is pending.
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken with result pending");

  // Once a word is taken the input side is closed in the cycle after.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input stayed open after a word was taken");

  // Velocity only with an accepted position.
  a_vel: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.velocity_ok |-> out_data.position_ok && out_data.identity_ok)
    else $error("velocity without position");

  // Acceleration only with a velocity.
  a_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.accel_ok |-> out_data.velocity_ok)
    else $error("acceleration without velocity");
endmodule

bind finite_difference_motion_estimator_top fdme_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
